### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared entry and control types, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Command codes carried on in_tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 5;

  // One stored entry
  typedef struct packed {
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;      // insert takes effect this cycle
    logic   rem;      // removal takes effect this cycle
    entry_t new_ent;  // entry being inserted
  } ctrl_t;

endpackage

`default_nettype wire

### hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted by ascending signed priority in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one command per request: in_tuser selects insert
//   or remove-front, in_tdata holds the value and priority of an insert.
//   Equal priorities keep arrival order. Every request yields exactly one
//   result on the out_ channel: the head entry (zero when empty), the entry
//   count, an empty flag and a status (ok, insert dropped because full,
//   remove on empty queue).
//   The result is registered: it is valid the cycle after acceptance.
//   One request is taken per cycle while the receiver keeps up; every cell
//   updates in parallel, comparing its priority to the broadcast new entry.
//   A waiting result occupies the output register; a new request is taken
//   in the same cycle that result is taken, so a stalled receiver holds the
//   input side off only while its result waits.
//   Reset empties the queue (occupancy zero) and drops any pending result;
//   slot contents are not cleared and are never shown unless written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // value [31:0], priority_req [47:32]
  input  wire  [0:0]  in_tuser,   // command [0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata   // head_value [31:0], head_priority [47:32],
                                  // entry_count [52:48], is_empty [53],
                                  // status [55:54]
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [1:0]       status_r, status_nxt;

  logic             in_acc;
  logic             is_full, is_zero;
  spq_pkg::ctrl_t   ctrl;
  spq_pkg::entry_t  ent  [QUEUE_DEPTH];
  logic             stay [QUEUE_DEPTH];
  logic             vld  [QUEUE_DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_zero   = (count_r == '0);

  // Decode the command into the broadcast control
  always_comb begin
    ctrl.new_ent.value = in_tdata[31:0];
    ctrl.new_ent.prio  = in_tdata[47:32];
    ctrl.ins = in_acc && (in_tuser[0] == spq_pkg::CMD_INSERT) && !is_full;
    ctrl.rem = in_acc && (in_tuser[0] == spq_pkg::CMD_REMOVE) && !is_zero;
  end

  // Status and occupancy update
  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    if (in_tuser[0] == spq_pkg::CMD_INSERT) begin
      if (is_full) begin
        status_nxt = spq_pkg::ST_FULL;
      end
    end else begin
      if (is_zero) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end
    end
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Row of cells
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      spq_pkg::entry_t prev_ent, next_ent;
      logic            prev_stay;

      assign vld[gi] = (count_r > CNT_W'(gi));

      if (gi == 0) begin : g_head
        assign prev_ent  = ctrl.new_ent;
        assign prev_stay = 1'b1;
      end else begin : g_body
        assign prev_ent  = ent[gi-1];
        assign prev_stay = stay[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign next_ent = ent[gi];
      end else begin : g_mid
        assign next_ent = ent[gi+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .slot_vld  (vld[gi]),
        .prev_stay (prev_stay),
        .prev_ent  (prev_ent),
        .next_ent  (next_ent),
        .ent       (ent[gi]),
        .stay      (stay[gi])
      );
    end
  endgenerate

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= spq_pkg::ST_OK;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result: head is read live from the first cell, which changes only on an
  // accepted request and so never while a result waits untaken
  assign out_tvalid       = out_valid_r;
  assign out_tdata[31:0]  = is_zero ? '0 : ent[0].value;
  assign out_tdata[47:32] = is_zero ? '0 : ent[0].prio;
  assign out_tdata[52:48] = spq_pkg::COUNT_W'(count_r);
  assign out_tdata[53]    = is_zero;
  assign out_tdata[55:54] = status_r;

  // Occupancy stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  // Insert on a full queue leaves it unchanged and reports full
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == spq_pkg::CMD_INSERT && is_full) |=>
      (status_r == spq_pkg::ST_FULL) && $stable(count_r))
    else $error("insert on full queue not dropped");

  // Removal on a non-empty queue shrinks it by one
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == spq_pkg::CMD_REMOVE && !is_zero) |=>
      (count_r == $past(count_r) - 1'b1) && (status_r == spq_pkg::ST_OK))
    else $error("removal did not shrink queue");

  // Input is open whenever no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input blocked with empty output register");

endmodule

`default_nettype wire

### hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one slot; on insert it stays, takes the new entry or takes its left
// neighbor; on removal it takes its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                 clk,
  input  spq_pkg::ctrl_t      ctrl,
  input  wire                 slot_vld,   // slot lies below the occupancy
  input  wire                 prev_stay,  // left neighbor keeps its entry
  input  spq_pkg::entry_t     prev_ent,
  input  spq_pkg::entry_t     next_ent,
  output spq_pkg::entry_t     ent,
  output logic                stay        // this slot keeps its entry on insert
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;

  // A valid slot stays in place unless the new priority is strictly smaller
  assign stay = slot_vld && !(ent_r.prio > ctrl.new_ent.prio);
  assign ent  = ent_r;

  // Select the next slot content
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins) begin
      if (stay) begin
        ent_nxt = ent_r;
      end else if (prev_stay) begin
        ent_nxt = ctrl.new_ent;
      end else begin
        ent_nxt = prev_ent;
      end
    end else if (ctrl.rem) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove-front requests through the stream ports with
// random gaps and output stalls, predicts the head, count, empty flag and
// status of every result, and checks each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH     = 16;
  localparam int RAND_REQS = 2000;

  // Expected content of one result
  typedef struct {
    logic signed [spq_pkg::VALUE_W-1:0] head_value;
    logic signed [spq_pkg::PRIO_W-1:0]  head_prio;
    logic [spq_pkg::COUNT_W-1:0]        count;
    logic                               empty;
    logic [1:0]                         status;
  } queue_result_t;

  // Sorted-queue predictor and store of expected results
  class queue_scoreboard;
    logic signed [spq_pkg::VALUE_W-1:0] slot_val [DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0]  slot_prio [DEPTH];
    int                                 occupancy;
    queue_result_t                      expected_q [$];
    int mismatches, checked, inserts, removes, full_drops, empty_removes, full_hits;

    function new();
      occupancy = 0;
      mismatches = 0;
      checked = 0;
      inserts = 0;
      removes = 0;
      full_drops = 0;
      empty_removes = 0;
      full_hits = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the shadow queue and queue its result
    function void note_request(logic cmd, logic signed [spq_pkg::VALUE_W-1:0] value,
                               logic signed [spq_pkg::PRIO_W-1:0] prio);
      queue_result_t res;
      int            pos;
      int            i;
      res.status = spq_pkg::ST_OK;
      if (cmd == spq_pkg::CMD_INSERT) begin
        inserts++;
        if (occupancy >= DEPTH) begin
          res.status = spq_pkg::ST_FULL;
          full_drops++;
        end else begin
          // land behind every entry of equal or smaller priority
          pos = 0;
          while (pos < occupancy && slot_prio[pos] <= prio) pos++;
          for (i = occupancy; i > pos; i--) begin
            slot_val[i]  = slot_val[i-1];
            slot_prio[i] = slot_prio[i-1];
          end
          slot_val[pos]  = value;
          slot_prio[pos] = prio;
          occupancy++;
          if (occupancy == DEPTH) full_hits++;
        end
      end else begin
        removes++;
        if (occupancy == 0) begin
          res.status = spq_pkg::ST_EMPTY;
          empty_removes++;
        end else begin
          for (i = 1; i < occupancy; i++) begin
            slot_val[i-1]  = slot_val[i];
            slot_prio[i-1] = slot_prio[i];
          end
          occupancy--;
        end
      end
      res.empty      = (occupancy == 0);
      res.head_value = res.empty ? '0 : slot_val[0];
      res.head_prio  = res.empty ? '0 : slot_prio[0];
      res.count      = occupancy[spq_pkg::COUNT_W-1:0];
      expected_q.push_back(res);
    endfunction

    task report(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(logic [55:0] word);
      queue_result_t want;
      if (expected_q.size() == 0) begin
        report("result with no request waiting", '0, word);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (word[31:0] !== want.head_value) report("head_value", want.head_value, word[31:0]);
      if (word[47:32] !== want.head_prio) report("head_priority", want.head_prio, word[47:32]);
      if (word[52:48] !== want.count) report("entry_count", want.count, word[52:48]);
      if (word[53] !== want.empty) report("is_empty", want.empty, word[53]);
      if (word[55:54] !== want.status) report("status", want.status, word[55:54]);
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [47:0] in_tdata   = '0;   // value [31:0], priority_req [47:32]
  logic [0:0]  in_tuser   = '0;   // command [0]
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [55:0] out_tdata;         // head_value [31:0], head_priority [47:32],
                                  // entry_count [52:48], is_empty [53],
                                  // status [55:54]

  queue_scoreboard sb;
  bit send_quiet  = 1'b0;
  bit stall_quiet = 1'b0;
  int stall_left  = 0;

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Cluster priorities near zero for ties, with the extremes and full range too
  function automatic logic [15:0] rand_prio();
    int r;
    r = $urandom_range(0, 7);
    if (r < 4) return 16'($signed($urandom_range(0, 6)) - 3);
    if (r == 4) return 16'h8000 + 16'($urandom_range(0, 2));
    if (r == 5) return 16'h7fff - 16'($urandom_range(0, 2));
    return 16'($urandom());
  endfunction

  // Stall the receiver at random
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else stall_left = pick_gap(stall_quiet);
    out_tready <= (stall_left == 0);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_request(input logic cmd, input logic [31:0] value,
                              input logic [15:0] prio);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {prio, value};
    in_tuser  <= cmd;
    do begin
      @(posedge clk);
    end while (in_tready !== 1'b1);
    sb.note_request(cmd, value, prio);
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int phase_left;
    int ins_pct;
    int i;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: remove on empty, extremes, ties, fill, insert on full, six removes
    send_request(spq_pkg::CMD_REMOVE, 32'hffffffff, 16'hffff);
    send_request(spq_pkg::CMD_INSERT, 32'h7fffffff, 16'h7fff);
    send_request(spq_pkg::CMD_INSERT, 32'h80000000, 16'h8000);
    send_request(spq_pkg::CMD_INSERT, 32'h00000001, 16'h8000);
    send_request(spq_pkg::CMD_INSERT, 32'h00000000, 16'h0000);
    for (i = 0; i < 11; i++) begin
      send_request(spq_pkg::CMD_INSERT, 32'h100 + 32'(i), 16'(i % 3) - 16'd1);
    end
    send_request(spq_pkg::CMD_INSERT, 32'hffffffff, 16'h8000);
    send_request(spq_pkg::CMD_INSERT, 32'h12345678, 16'h0000);
    for (i = 0; i < 6; i++) begin
      send_request(spq_pkg::CMD_REMOVE, 32'($urandom()), 16'($urandom()));
    end
    wait_drained();

    // Random phases that swing the queue between empty and full
    sent = 0;
    while (sent < RAND_REQS) begin
      phase_left  = $urandom_range(20, 120);
      send_quiet  = ($urandom_range(0, 3) == 0);
      stall_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0: ins_pct = 85;
        1: ins_pct = 15;
        2: ins_pct = 50;
        3: ins_pct = 100;
        default: ins_pct = 0;
      endcase
      while (phase_left > 0 && sent < RAND_REQS) begin
        send_request(($urandom_range(0, 99) < ins_pct) ?
                       spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE,
                     $urandom(), rand_prio());
        phase_left--;
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    // Let the last results arrive
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Covered %0d requests (%0d inserts, %0d removes), %0d results checked.",
             sb.inserts + sb.removes, sb.inserts, sb.removes, sb.checked);
    $display("Queue filled %0d times, %0d inserts dropped when full, %0d removes on empty.",
             sb.full_hits, sb.full_drops, sb.empty_removes);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
